// ===== design/ltg_pkg.sv =====
`timescale 1ns / 1ps

package ltg_pkg;

  // Command codes carried in the input tuser.
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CONVERT = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_LAYER_TOTAL = 3'd2,
    REG_TILE_KINDS  = 3'd3,
    REG_ORIGIN_X    = 3'd4,
    REG_ORIGIN_Y    = 3'd5,
    REG_TILE_WIDTH  = 3'd6,
    REG_TILE_HEIGHT = 3'd7
  } reg_t;

  // Geometry as seen by the sequencer, with sizes already clamped to the maxima.
  typedef struct packed {
    logic [7:0]  eff_width;
    logic [7:0]  eff_height;
    logic [2:0]  eff_layers;
    logic [15:0] tile_kinds;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [15:0] tile_width;
    logic [15:0] tile_height;
  } geom_t;

  // Stream payload widths.
  localparam int S_TDATA_W = 120;
  localparam int M_TDATA_W = 88;

  // Divider geometry: two quotient bits per cycle.
  localparam int DIV_W     = 32;
  localparam int DVS_W     = 16;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Saturation limits of the converted coordinates.
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage

// ===== design/layered_tile_grid_store_core.sv =====
// Channel  Direction  Beat contents
// s_*      in         tuser: command; tdata: cell_x, cell_y, layer_no, new_index,
//                     world_x, world_y
// m_*      out        tuser: status; tdata: tile_value, grid_col, grid_row, inside_map
// cfg_*    in         cfg_index selects the register, cfg_data carries the value
//
// One command at a time through a small sequencer. A write steps through ADDR1,
// ADDR2 (address multiply steps) and MEM, a read adds the registered memory read
// (RDWAIT), an unknown command goes straight to DONE, and a world conversion
// runs two passes of the shared 2-bit-per-cycle divider, one per axis.
// After reset a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT*MAX_LAYERS
// entries, one per cycle, with s_tready low; config writes are taken throughout.
// A finished result waits in the output register while the next beat is taken.
`timescale 1ns / 1ps

module layered_tile_grid_store_core #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_LAYERS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // cell_x[15:0], cell_y[31:16], layer_no[35:32], new_index[51:36],
  // world_x[83:52], world_y[115:84], zero fill above
  input  logic [ltg_pkg::S_TDATA_W-1:0] s_tdata,
  // command[1:0]
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tile_value[15:0], grid_col[47:16], grid_row[79:48], inside_map[80], zero fill above
  output logic [ltg_pkg::M_TDATA_W-1:0] m_tdata,
  // status[0]
  output logic                          m_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  import ltg_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_LAYERS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [9:0] {
    S_CLEAR     = 10'b0000000001,
    S_IDLE      = 10'b0000000010,
    S_ADDR1     = 10'b0000000100,
    S_ADDR2     = 10'b0000001000,
    S_MEM       = 10'b0000010000,
    S_RDWAIT    = 10'b0000100000,
    S_DIVX_GO   = 10'b0001000000,
    S_DIVX_WAIT = 10'b0010000000,
    S_DIVY_GO   = 10'b0100000000,
    S_DONE      = 10'b1000000000
  } state_t;

  state_t state;
  state_t divy_wait;
  geom_t  geom;

  // Latched command.
  cmd_t        cmd;
  logic [15:0] cx;
  logic [15:0] cy;
  logic [3:0]  lay;
  logic [15:0] nidx;
  logic [32:0] dx;
  logic [32:0] dy;

  // Working registers.
  logic              cell_ok;
  logic [15:0]       lin;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] clr_addr;
  logic              res_status;
  logic [15:0]       res_value;
  logic [31:0]       res_col;
  logic [31:0]       res_row;
  logic              in_x;
  logic              in_y;
  logic              y_pass;

  // Memory and divider hookup.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [15:0]       ram_wdata;
  logic [15:0]       ram_rdata;
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;

  // Combinational helpers.
  logic        x_ok;
  logic        y_ok;
  logic        l_ok;
  logic        wr_ok;
  logic [15:0] lin_next;
  logic [18:0] addr_next;
  logic [32:0] dsel;
  logic [32:0] dmag;
  logic        q_neg;
  logic [7:0]  q_lim;
  logic [31:0] q_sat;
  logic        q_in;

  assign divy_wait = S_DIVX_WAIT;
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);

  ltg_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_LAYERS (MAX_LAYERS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  ltg_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  ltg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Range checks and address arithmetic on the latched cell position.
  always_comb begin
    x_ok      = !cx[15] && (cx[14:0] < {7'b0, geom.eff_width});
    y_ok      = !cy[15] && (cy[14:0] < {7'b0, geom.eff_height});
    l_ok      = !lay[3] && (lay[2:0] < geom.eff_layers);
    wr_ok     = cell_ok && (nidx < geom.tile_kinds);
    lin_next  = ({8'b0, geom.eff_width} * {8'b0, cy[7:0]}) + {8'b0, cx[7:0]};
    addr_next = ({16'b0, geom.eff_layers} * {3'b0, lin}) + {16'b0, lay[2:0]};
  end

  // Memory port: the clearing pass or the command's cell.
  always_comb begin
    ram_we    = (state == S_CLEAR) || ((state == S_MEM) && (cmd == CMD_WRITE) && wr_ok);
    ram_addr  = (state == S_CLEAR) ? clr_addr : addr;
    ram_wdata = (state == S_CLEAR) ? 16'd0 : nidx;
  end

  // Divider operands: magnitude of the offset, sign kept in dx or dy.
  always_comb begin
    dsel         = (state == S_DIVY_GO) ? dy : dx;
    dmag         = dsel[32] ? (~dsel + 33'd1) : dsel;
    div_dividend = dmag[DIV_W-1:0];
    div_divisor  = (state == S_DIVY_GO) ? geom.tile_height : geom.tile_width;
    div_start    = (state == S_DIVX_GO) || (state == S_DIVY_GO);
  end

  // Signed quotient with saturation and the in-map test on the exact value.
  always_comb begin
    q_neg = y_pass ? dy[32] : dx[32];
    q_lim = y_pass ? geom.eff_height : geom.eff_width;
    if (q_neg) begin
      q_sat = (div_quo > SAT_NEG) ? SAT_NEG : (~div_quo + 32'd1);
    end else begin
      q_sat = (div_quo > SAT_POS) ? SAT_POS : div_quo;
    end
    q_in = (!q_neg || (div_quo == '0)) && (div_quo < {24'b0, q_lim});
  end

  // Command sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
      y_pass   <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one loads now.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd        <= cmd_t'(s_tuser);
            cx         <= s_tdata[15:0];
            cy         <= s_tdata[31:16];
            lay        <= s_tdata[35:32];
            nidx       <= s_tdata[51:36];
            dx         <= {s_tdata[83], s_tdata[83:52]} - {geom.origin_x[31], geom.origin_x};
            dy         <= {s_tdata[115], s_tdata[115:84]} - {geom.origin_y[31], geom.origin_y};
            res_value  <= 16'd0;
            res_col    <= 32'd0;
            res_row    <= 32'd0;
            in_x       <= 1'b0;
            in_y       <= 1'b0;
            y_pass     <= 1'b0;
            unique case (cmd_t'(s_tuser)) inside
              CMD_WRITE, CMD_READ: begin
                res_status <= 1'b0;
                state      <= S_ADDR1;
              end
              CMD_CONVERT: begin
                res_status <= 1'b0;
                state      <= S_DIVX_GO;
              end
              default: begin
                res_status <= 1'b1;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_ADDR1: begin
          cell_ok <= x_ok && y_ok && l_ok;
          lin     <= lin_next;
          state   <= S_ADDR2;
        end
        S_ADDR2: begin
          addr  <= ADDR_W'(addr_next);
          state <= S_MEM;
        end
        S_MEM: begin
          if (cmd == CMD_WRITE) begin
            res_status <= !wr_ok;
            state      <= S_DONE;
          end else begin
            state <= S_RDWAIT;
          end
        end
        S_RDWAIT: begin
          if (cell_ok) begin
            res_value  <= ram_rdata;
            res_status <= (ram_rdata >= geom.tile_kinds);
          end else begin
            res_status <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DIVX_GO: begin
          state <= S_DIVX_WAIT;
        end
        S_DIVX_WAIT: begin
          if (div_done) begin
            if (y_pass) begin
              res_row <= q_sat;
              in_y    <= q_in;
              state   <= S_DONE;
            end else begin
              res_col <= q_sat;
              in_x    <= q_in;
              state   <= S_DIVY_GO;
            end
          end
        end
        S_DIVY_GO: begin
          y_pass <= 1'b1;
          state  <= divy_wait;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {7'b0, in_x && in_y, res_row, res_col, res_value};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == S_IDLE)) else $error("input ready outside idle");

  a_ram_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_CLEAR) || (state == S_MEM)))
    else $error("memory written outside clear or cell access");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVX_WAIT)) else $error("divider finished with no waiter");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE)) else $error("result loaded outside done");

endmodule

// ===== design/ltg_ram.sv =====
`timescale 1ns / 1ps

module ltg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                             wdata,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, read data registered, read returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/ltg_cfg.sv =====
`timescale 1ns / 1ps

module ltg_cfg #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_LAYERS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output ltg_pkg::geom_t geom
);
  import ltg_pkg::*;

  logic [7:0]  grid_width;
  logic [7:0]  grid_height;
  logic [2:0]  layer_total;
  logic [15:0] tile_kinds;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [15:0] tile_width;
  logic [15:0] tile_height;

  // Register file; the port is always ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 8'd128;
      grid_height <= 8'd128;
      layer_total <= 3'd1;
      tile_kinds  <= 16'd0;
      origin_x    <= 32'd0;
      origin_y    <= 32'd0;
      tile_width  <= 16'd16;
      tile_height <= 16'd16;
    end else if (cfg_valid) begin
      unique case (reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data[7:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[7:0];
        REG_LAYER_TOTAL: layer_total <= cfg_data[2:0];
        REG_TILE_KINDS:  tile_kinds  <= cfg_data[15:0];
        REG_ORIGIN_X:    origin_x    <= cfg_data;
        REG_ORIGIN_Y:    origin_y    <= cfg_data;
        REG_TILE_WIDTH:  tile_width  <= cfg_data[15:0];
        REG_TILE_HEIGHT: tile_height <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sizes above the store's maxima act as the maxima.
  always_comb begin
    geom.eff_width   = (int'(grid_width) > MAX_WIDTH) ? 8'(MAX_WIDTH) : grid_width;
    geom.eff_height  = (int'(grid_height) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : grid_height;
    geom.eff_layers  = (int'(layer_total) > MAX_LAYERS) ? 3'(MAX_LAYERS) : layer_total;
    geom.tile_kinds  = tile_kinds;
    geom.origin_x    = origin_x;
    geom.origin_y    = origin_y;
    geom.tile_width  = tile_width;
    geom.tile_height = tile_height;
  end

endmodule

// ===== design/ltg_div.sv =====
`timescale 1ns / 1ps

module ltg_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ltg_pkg::DIV_W-1:0] dividend,
  input  logic [ltg_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [ltg_pkg::DIV_W-1:0] quotient
);
  import ltg_pkg::*;

  logic [DIV_W-1:0]     dq;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_W-1:0]     dq_next;
  logic [DVS_W-1:0]     rem_next;

  // Two restoring steps per cycle. The dividend shifts out at the top while
  // quotient bits enter at the bottom of the same register.
  always_comb begin
    logic [DVS_W:0]   t;
    logic [DVS_W-1:0] r;
    logic [DIV_W-1:0] q;
    r = rem;
    q = dq;
    for (int k = 0; k < 2; k++) begin
      t = {r, q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t    = t - {1'b0, dvs};
        q[0] = 1'b1;
      end
      r = t[DVS_W-1:0];
    end
    dq_next  = q;
    rem_next = r;
  end

  // Iteration control; a zero divisor divides as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
        dq   <= dividend;
        rem  <= '0;
        dvs  <= (divisor == '0) ? DVS_W'(1) : divisor;
      end else if (busy) begin
        dq  <= dq_next;
        rem <= rem_next;
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dq;

  a_no_zero_dvs: assert property (@(posedge clk) disable iff (rst)
    busy |-> (dvs != '0)) else $error("divisor register is zero while iterating");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < dvs)) else $error("partial remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy))) else $error("done without a finished iteration");

endmodule

// ===== sim/layered_tile_grid_store_core_tb.sv =====
`timescale 1ns / 1ps

module layered_tile_grid_store_core_tb;
  import ltg_pkg::*;

  localparam int MAP_MAX_W     = 128;
  localparam int MAP_MAX_H     = 128;
  localparam int MAP_MAX_L     = 4;
  localparam int STORE_DEPTH   = MAP_MAX_W * MAP_MAX_H * MAP_MAX_L;
  localparam int SHADOW_AW     = $clog2(STORE_DEPTH);
  localparam int QUIET_LIMIT   = 300000;
  localparam int DRAIN_PAUSE   = 48;
  localparam int HOLD_CYCLES   = 400;
  localparam int ITEMS_PER_SET = 55;
  localparam int PRESSURE_BURST = 30;
  localparam int MAX_REPORTS   = 40;

  // One command beat as the sender builds it.
  typedef struct packed {
    cmd_t               op;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [3:0]  layer_no;
    logic [15:0]        new_index;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
  } grid_item_t;

  // One result beat, unpacked.
  typedef struct packed {
    logic        status;
    logic [15:0] tile_value;
    logic [31:0] grid_col;
    logic [31:0] grid_row;
    logic        inside_map;
  } grid_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [1:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [2:0]           cfg_index;
  logic [31:0]          cfg_data;

  // Shadow copy of the map registers and the tile memory.
  logic [7:0]         map_width;
  logic [7:0]         map_height;
  logic [2:0]         map_layers;
  logic [15:0]        map_kinds;
  logic signed [31:0] map_org_x;
  logic signed [31:0] map_org_y;
  logic [15:0]        map_tile_w;
  logic [15:0]        map_tile_h;
  logic [15:0]        tile_shadow [0:STORE_DEPTH-1];

  grid_result_t expected_results [$];

  int err_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int cfg_beats = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_pending = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  layered_tile_grid_store_core #(
    .MAX_WIDTH (MAP_MAX_W),
    .MAX_HEIGHT(MAP_MAX_H),
    .MAX_LAYERS(MAP_MAX_L)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sizes above the maxima behave as the maxima.
  function automatic int eff_width();
    return (int'(map_width) > MAP_MAX_W) ? MAP_MAX_W : int'(map_width);
  endfunction

  function automatic int eff_height();
    return (int'(map_height) > MAP_MAX_H) ? MAP_MAX_H : int'(map_height);
  endfunction

  function automatic int eff_layers();
    return (int'(map_layers) > MAP_MAX_L) ? MAP_MAX_L : int'(map_layers);
  endfunction

  function automatic logic [31:0] clamp_to_int32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
    if (v < -longint'(32'sh7FFF_FFFF) - 1) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Works out the result of one command and applies any write to the shadow memory.
  function automatic grid_result_t predict_grid_op(grid_item_t it);
    grid_result_t r;
    int x, y, ly, addr;
    logic [SHADOW_AW-1:0] saddr;
    bit hit;
    longint dx, dy, qx, qy, div_x, div_y;
    r = '0;
    x = int'(it.cell_x);
    y = int'(it.cell_y);
    ly = int'(it.layer_no);
    hit = x >= 0 && x < eff_width() && y >= 0 && y < eff_height() &&
          ly >= 0 && ly < eff_layers();
    addr = eff_layers() * (eff_width() * y + x) + ly;
    saddr = SHADOW_AW'(addr);
    case (it.op)
      CMD_WRITE: begin
        if (hit && it.new_index < map_kinds) tile_shadow[saddr] = it.new_index;
        else r.status = 1'b1;
      end
      CMD_READ: begin
        if (hit) begin
          r.tile_value = tile_shadow[saddr];
          r.status = (r.tile_value >= map_kinds);
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_CONVERT: begin
        // A zero tile size divides as one; longint division truncates toward zero.
        div_x = (map_tile_w == 0) ? longint'(1) : longint'(map_tile_w);
        div_y = (map_tile_h == 0) ? longint'(1) : longint'(map_tile_h);
        dx = longint'(it.world_x) - longint'(map_org_x);
        dy = longint'(it.world_y) - longint'(map_org_y);
        qx = dx / div_x;
        qy = dy / div_y;
        r.inside_map = qx >= 0 && qx < eff_width() && qy >= 0 && qy < eff_height();
        r.grid_col = clamp_to_int32(qx);
        r.grid_row = clamp_to_int32(qy);
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  function automatic grid_item_t cell_cmd(cmd_t op, int x, int y, int ly, int idx);
    grid_item_t it;
    it = '0;
    it.op = op;
    it.cell_x = 16'(x);
    it.cell_y = 16'(y);
    it.layer_no = 4'(ly);
    it.new_index = 16'(idx);
    return it;
  endfunction

  function automatic grid_item_t world_cmd(int wx, int wy);
    grid_item_t it;
    it = '0;
    it.op = CMD_CONVERT;
    it.world_x = wx;
    it.world_y = wy;
    return it;
  endfunction

  // Mostly well-formed commands aimed at the live map, with some pure noise.
  function automatic grid_item_t random_grid_item();
    grid_item_t it;
    int ew, eh, el, roll, twe, the;
    ew = eff_width();
    eh = eff_height();
    el = eff_layers();
    twe = (map_tile_w == 0) ? 1 : int'(map_tile_w);
    the = (map_tile_h == 0) ? 1 : int'(map_tile_h);
    it.op = cmd_t'(2'($urandom_range(3)));
    it.cell_x = 16'($urandom);
    it.cell_y = 16'($urandom);
    it.layer_no = 4'($urandom);
    it.new_index = 16'($urandom);
    it.world_x = $urandom;
    it.world_y = $urandom;
    roll = $urandom_range(99);
    if (roll < 8) return it;
    it.op = (roll < 45) ? CMD_WRITE : (roll < 78) ? CMD_READ : CMD_CONVERT;
    if (ew > 0 && eh > 0 && el > 0) begin
      it.cell_x = 16'($urandom_range(ew - 1));
      it.cell_y = 16'($urandom_range(eh - 1));
      it.layer_no = 4'($urandom_range(el - 1));
      // One coordinate just off the map now and then.
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: it.cell_x = 16'($urandom_range(1) ? -1 : ew);
          1: it.cell_y = 16'($urandom_range(1) ? -1 : eh);
          default: it.layer_no = 4'($urandom_range(1) ? -1 : el);
        endcase
      end
    end
    if (map_kinds > 0 && $urandom_range(7) != 0)
      it.new_index = 16'($urandom_range(map_kinds - 1));
    if ($urandom_range(7) != 0) begin
      it.world_x = map_org_x + int'($urandom_range(ew * twe + 2 * twe)) - twe;
      it.world_y = map_org_y + int'($urandom_range(eh * the + 2 * the)) - the;
    end
    return it;
  endfunction

  // Offers one command beat after a random gap and waits for it to be taken.
  task automatic send_item(grid_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= it.op;
    s_tdata <= {4'b0, it.world_y, it.world_x, it.new_index, it.layer_no, it.cell_y, it.cell_x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results = {expected_results, predict_grid_op(it)};
    op_count[it.op]++;
    items_sent++;
  endtask

  // Writes one register; cfg_valid stays high so back-to-back writes need no gap.
  task automatic cfg_write(reg_t r, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      REG_GRID_WIDTH:  map_width = v[7:0];
      REG_GRID_HEIGHT: map_height = v[7:0];
      REG_LAYER_TOTAL: map_layers = v[2:0];
      REG_TILE_KINDS:  map_kinds = v[15:0];
      REG_ORIGIN_X:    map_org_x = v;
      REG_ORIGIN_Y:    map_org_y = v;
      REG_TILE_WIDTH:  map_tile_w = v[15:0];
      default:         map_tile_h = v[15:0];
    endcase
    cfg_beats++;
  endtask

  task automatic cfg_release();
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic write_map_config(int w, int h, int l, int k, int ox, int oy, int tw, int th);
    cfg_write(REG_GRID_WIDTH, w);
    cfg_write(REG_GRID_HEIGHT, h);
    cfg_write(REG_LAYER_TOTAL, l);
    cfg_write(REG_TILE_KINDS, k);
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_TILE_WIDTH, tw);
    cfg_write(REG_TILE_HEIGHT, th);
    cfg_release();
  endtask

  // Stops offering beats and waits until every result is back and the core is idle.
  task automatic wait_results_drained();
    @(negedge clk) s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Reset values: one layer, no tile kinds defined, 16-unit tiles.
  task automatic test_reset_state();
    send_item(cell_cmd(CMD_READ, 0, 0, 0, 0));
    send_item(cell_cmd(CMD_WRITE, 5, 5, 0, 0));
    send_item(world_cmd(33, -17));
    send_item('1);
  endtask

  // Field extremes on a full-size map, then saturation and zero tile size.
  task automatic test_field_extremes();
    wait_results_drained();
    write_map_config(128, 128, 4, 65535, 0, 0, 1, 65535);
    send_item(cell_cmd(CMD_WRITE, 0, 0, 0, 65534));
    send_item(cell_cmd(CMD_WRITE, 127, 127, 3, 1));
    send_item(cell_cmd(CMD_WRITE, 127, 127, 3, 65535));
    send_item(cell_cmd(CMD_WRITE, -1, 0, 0, 7));
    send_item(cell_cmd(CMD_WRITE, 128, 5, 0, 7));
    send_item(cell_cmd(CMD_WRITE, 3, -32768, 0, 7));
    send_item(cell_cmd(CMD_WRITE, 32767, 0, 0, 7));
    send_item(cell_cmd(CMD_WRITE, 0, 0, -8, 7));
    send_item(cell_cmd(CMD_READ, 0, 0, 0, 0));
    send_item(cell_cmd(CMD_READ, 127, 127, 3, 0));
    send_item(cell_cmd(CMD_READ, 0, 0, 7, 0));
    send_item(world_cmd(32'h7FFF_FFFF, 32'h8000_0000));
    wait_results_drained();
    // Stored value at or above the kind count is flagged but still returned.
    cfg_write(REG_TILE_KINDS, 2);
    cfg_write(REG_ORIGIN_X, 32'h7FFF_FFFF);
    cfg_write(REG_ORIGIN_Y, 32'h8000_0000);
    cfg_write(REG_TILE_WIDTH, 0);
    cfg_write(REG_TILE_HEIGHT, 0);
    cfg_release();
    send_item(cell_cmd(CMD_READ, 0, 0, 0, 0));
    send_item(world_cmd(32'h8000_0000, 32'h7FFF_FFFF));
    send_item(world_cmd(32'h7FFF_FFFF, 32'h8000_0000));
  endtask

  // Zero width empties the map; oversized sizes clamp to the maxima.
  task automatic test_geometry_limits();
    wait_results_drained();
    cfg_write(REG_GRID_WIDTH, 0);
    cfg_release();
    send_item(cell_cmd(CMD_READ, 0, 0, 0, 0));
    send_item(cell_cmd(CMD_WRITE, 0, 0, 0, 1));
    send_item(world_cmd(32'h7FFF_FFFF, 32'h8000_0000));
    wait_results_drained();
    cfg_write(REG_GRID_WIDTH, 200);
    cfg_write(REG_GRID_HEIGHT, 255);
    cfg_write(REG_LAYER_TOTAL, 7);
    cfg_release();
    send_item(cell_cmd(CMD_READ, 127, 127, 3, 0));
    send_item(cell_cmd(CMD_WRITE, 10, 10, 4, 1));
    send_item(cell_cmd(CMD_WRITE, 127, 0, 3, 1));
    send_item(cell_cmd(CMD_READ, 127, 0, 3, 0));
  endtask

  // Random map settings under each idle pattern; stored tiles carry over between
  // settings, so changed geometry reinterprets old data.
  task automatic test_random_traffic();
    int idle_sel [4] = '{0, 56, 0, 24};
    int stall_sel [4] = '{0, 0, 56, 24};
    for (int ph = 0; ph < 4; ph++) begin
      for (int s = 0; s < 5; s++) begin
        wait_results_drained();
        send_idle_pct = idle_sel[ph];
        stall_pct = stall_sel[ph];
        if (s == 0) begin
          write_map_config(128, 128, 4, 65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 65535, 65535);
        end else if (s == 1) begin
          write_map_config(1, 1, 1, 0, 32'h8000_0000, 32'h8000_0000, 0, 1);
        end else begin
          write_map_config($urandom_range(4) == 0 ? $urandom_range(255) : $urandom_range(1, 16),
                           $urandom_range(4) == 0 ? $urandom_range(255) : $urandom_range(1, 16),
                           $urandom_range(7),
                           $urandom_range(2) == 0 ? $urandom_range(65535) : $urandom_range(1, 64),
                           $urandom_range(1) ? $urandom : $urandom_range(2000) - 1000,
                           $urandom_range(1) ? $urandom : $urandom_range(2000) - 1000,
                           $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(40),
                           $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(40));
        end
        repeat (ITEMS_PER_SET) send_item(random_grid_item());
      end
    end
  endtask

  // Long output hold-off while commands keep coming, so the input backs up.
  task automatic test_output_backpressure();
    wait_results_drained();
    write_map_config(12, 9, 3, 300, -50, 77, 5, 3);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_pending = 1'b1;
    repeat (PRESSURE_BURST) send_item(random_grid_item());
  endtask

  // Output ready: random stalls, plus a long hold-off counted here on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic report_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // Compare every result beat with the oldest outstanding prediction.
  always @(posedge clk) begin : result_check
    grid_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser;
      got.tile_value = m_tdata[15:0];
      got.grid_col = m_tdata[47:16];
      got.grid_row = m_tdata[79:48];
      got.inside_map = m_tdata[80];
      if (expected_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t ns: result beat with nothing expected, expected none, actual %h",
                   $time, got);
      end else begin
        want = expected_results.pop_front();
        report_field("status", 32'(want.status), 32'(got.status));
        report_field("tile_value", 32'(want.tile_value), 32'(got.tile_value));
        report_field("grid_col", want.grid_col, got.grid_col);
        report_field("grid_row", want.grid_row, got.grid_row);
        report_field("inside_map", 32'(want.inside_map), 32'(got.inside_map));
        results_checked++;
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (tile_shadow[a]) tile_shadow[a] = '0;
    map_width = 8'd128;
    map_height = 8'd128;
    map_layers = 3'd1;
    map_kinds = '0;
    map_org_x = '0;
    map_org_y = '0;
    map_tile_w = 16'd16;
    map_tile_h = 16'd16;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_reset_state();
    test_field_extremes();
    test_geometry_limits();
    test_random_traffic();
    test_output_backpressure();
    wait_results_drained();

    if (expected_results.size() != 0) begin
      err_count++;
      $display("%0t ns: results missing, expected %0d more, actual 0",
               $time, expected_results.size());
    end
    $display("Ran %0d commands (%0d writes, %0d reads, %0d conversions, %0d unknown), %0d checked.",
             items_sent, op_count[CMD_WRITE], op_count[CMD_READ], op_count[CMD_CONVERT],
             op_count[CMD_UNUSED], results_checked);
    $display("Used %0d register writes across map settings, idle patterns and one long hold-off.",
             cfg_beats);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
